@@ sv/tgql_pkg.sv @@
// ----------------------------------------------------------------------------
// tgql_pkg
// Types, constants and fixed-point helpers shared by the glyph quad layout.
// ----------------------------------------------------------------------------
`default_nettype none

package tgql_pkg;

    localparam int TAB_SPACES     = 4;
    localparam int POSITION_WIDTH = 24;
    localparam int OUT_W          = 24;
    localparam int EXT_W          = 40;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int NUM_VTX   = 6;
    localparam int VTX_CNT_W = $clog2(NUM_VTX);
    localparam logic [VTX_CNT_W-1:0] VTX_FIRST = VTX_CNT_W'(0);
    localparam logic [VTX_CNT_W-1:0] VTX_LAST  = VTX_CNT_W'(NUM_VTX - 1);

    // per-vertex corner pick: bit set selects left x / u0, top y / v0
    localparam logic [NUM_VTX-1:0] USE_LEFT = 6'b010011;
    localparam logic [NUM_VTX-1:0] USE_TOP  = 6'b001101;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_NL_BEARING_Y = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NL_SIZE_Y    = 1'b1;

    localparam logic signed [POSITION_WIDTH-1:0] POS_HI = {1'b0, {(POSITION_WIDTH-1){1'b1}}};
    localparam logic signed [POSITION_WIDTH-1:0] POS_LO = {1'b1, {(POSITION_WIDTH-1){1'b0}}};

    typedef logic signed [POSITION_WIDTH-1:0] pos_t;
    typedef logic signed [EXT_W-1:0]          ext_t;

    typedef struct packed {
        logic               string_start;
        logic        [7:0]  char_code;
        logic signed [15:0] bearing_x;
        logic signed [15:0] bearing_y;
        logic signed [15:0] glyph_width;
        logic signed [15:0] glyph_height;
        logic signed [15:0] advance_x;
        logic        [15:0] tex_u0;
        logic        [15:0] tex_v0;
        logic        [15:0] tex_u1;
        logic        [15:0] tex_v1;
    } glyph_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] vertex_x;
        logic signed [OUT_W-1:0] vertex_y;
        logic        [15:0]      vertex_u;
        logic        [15:0]      vertex_v;
        logic                    last_vertex;
        logic signed [OUT_W-1:0] bound_min_x;
        logic signed [OUT_W-1:0] bound_min_y;
        logic signed [OUT_W-1:0] bound_max_x;
        logic signed [OUT_W-1:0] bound_max_y;
    } vertex_t;

    typedef struct packed {
        logic        clear_box;
        pos_t        x_left;
        pos_t        x_right;
        pos_t        y_top;
        pos_t        y_bottom;
        logic [15:0] u0;
        logic [15:0] v0;
        logic [15:0] u1;
        logic [15:0] v1;
    } quad_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    function automatic ext_t ext_pos(input pos_t v);
        return EXT_W'(v);
    endfunction

    function automatic ext_t ext16(input logic signed [15:0] v);
        return EXT_W'(v);
    endfunction

    function automatic pos_t sat_pos(input ext_t v);
        pos_t r;
        if (v > ext_pos(POS_HI))
            r = POS_HI;
        else if (v < ext_pos(POS_LO))
            r = POS_LO;
        else
            r = POSITION_WIDTH'(v);
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input pos_t v);
        logic signed [31:0] t;
        t = 32'(v);
        return t[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/tgql_front.sv @@
// ----------------------------------------------------------------------------
// tgql_front
// Takes glyph beats, keeps the pen, resolves whitespace and queues quads.
// ----------------------------------------------------------------------------
`default_nettype none

module tgql_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              glyph_valid,
    output logic                                   glyph_ready,
    input  wire tgql_pkg::glyph_t                  glyph,
    input  wire logic                              cfg_we,
    input  wire logic [tgql_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tgql_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire tgql_pkg::q_status_t               q_status,
    output logic                                   q_push,
    output tgql_pkg::quad_t                        q_data
);

    logic signed [15:0] nl_bearing_reg;
    logic signed [15:0] nl_size_reg;
    tgql_pkg::pos_t     pen_x_reg, pen_x_next;
    tgql_pkg::pos_t     pen_y_reg, pen_y_next;
    logic               clear_pend_reg, clear_pend_next;

    tgql_pkg::pos_t     start_y;
    tgql_pkg::pos_t     pen_x_eff;
    tgql_pkg::pos_t     pen_y_eff;
    tgql_pkg::ext_t     line_len;
    tgql_pkg::ext_t     adv;
    logic               accept;
    logic               is_glyph;

    assign glyph_ready = !q_status.full;
    assign accept      = glyph_valid && glyph_ready;

    assign start_y   = tgql_pkg::sat_pos(-(3 * tgql_pkg::ext16(nl_bearing_reg)
                                          - tgql_pkg::ext16(nl_size_reg)));
    assign pen_x_eff = glyph.string_start ? '0 : pen_x_reg;
    assign pen_y_eff = glyph.string_start ? start_y : pen_y_reg;
    assign line_len  = 3 * tgql_pkg::ext16(glyph.bearing_y) - tgql_pkg::ext16(glyph.glyph_height);
    assign adv       = tgql_pkg::ext16(glyph.advance_x);

    always_comb
    begin
        pen_x_next = pen_x_eff;
        pen_y_next = pen_y_eff;
        is_glyph   = 1'b0;
        case (glyph.char_code)
            tgql_pkg::CH_LF:
            begin
                pen_y_next = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_y_eff) - line_len);
                pen_x_next = '0;
            end
            tgql_pkg::CH_VT:
            begin
                pen_y_next = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_y_eff)
                                               - line_len * tgql_pkg::EXT_W'(tgql_pkg::TAB_SPACES));
                pen_x_next = '0;
            end
            tgql_pkg::CH_CR:
            begin
                pen_x_next = '0;
            end
            tgql_pkg::CH_SPACE:
            begin
                pen_x_next = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_x_eff) + adv);
            end
            tgql_pkg::CH_TAB:
            begin
                pen_x_next = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_x_eff)
                                               + adv * tgql_pkg::EXT_W'(tgql_pkg::TAB_SPACES));
            end
            tgql_pkg::CH_FF:
            begin
                pen_x_next = pen_x_eff;
            end
            default:
            begin
                pen_x_next = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_x_eff) + adv);
                is_glyph   = 1'b1;
            end
        endcase
    end

    // box reset from a whitespace beat is carried to the next quad
    always_comb
    begin
        clear_pend_next = clear_pend_reg;
        if (accept)
        begin
            if (is_glyph)
                clear_pend_next = 1'b0;
            else
                clear_pend_next = clear_pend_reg | glyph.string_start;
        end
    end

    assign q_push           = accept && is_glyph;
    assign q_data.clear_box = glyph.string_start | clear_pend_reg;
    assign q_data.x_left    = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_x_eff)
                                                + tgql_pkg::ext16(glyph.bearing_x));
    assign q_data.x_right   = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_x_eff)
                                                + tgql_pkg::ext16(glyph.bearing_x)
                                                + tgql_pkg::ext16(glyph.glyph_width));
    assign q_data.y_top     = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_y_eff)
                                                + tgql_pkg::ext16(glyph.bearing_y));
    assign q_data.y_bottom  = tgql_pkg::sat_pos(tgql_pkg::ext_pos(pen_y_eff)
                                                + tgql_pkg::ext16(glyph.bearing_y)
                                                - tgql_pkg::ext16(glyph.glyph_height));
    assign q_data.u0        = glyph.tex_u0;
    assign q_data.v0        = glyph.tex_v0;
    assign q_data.u1        = glyph.tex_u1;
    assign q_data.v1        = glyph.tex_v1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nl_bearing_reg <= '0;
            nl_size_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgql_pkg::CFG_NL_BEARING_Y: nl_bearing_reg <= cfg_data;
                tgql_pkg::CFG_NL_SIZE_Y:    nl_size_reg    <= cfg_data;
                default:                    nl_size_reg    <= nl_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            clear_pend_reg <= 1'b0;
        end
        else
        begin
            clear_pend_reg <= clear_pend_next;
            if (accept)
            begin
                pen_x_reg <= pen_x_next;
                pen_y_reg <= pen_y_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/tgql_queue.sv @@
// ----------------------------------------------------------------------------
// tgql_queue
// Short register queue of quads between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tgql_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire tgql_pkg::quad_t        push_data,
    input  wire logic                   pop,
    output tgql_pkg::q_status_t         status,
    output tgql_pkg::quad_t             head
);

    tgql_pkg::quad_t              slot_reg [tgql_pkg::QDEPTH];
    logic [tgql_pkg::QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tgql_pkg::QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tgql_pkg::QAW:0]       count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign status.full  = (count_reg == (tgql_pkg::QAW+1)'(tgql_pkg::QDEPTH));
    assign status.valid = (count_reg != '0);
    assign head         = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/tgql_back.sv @@
// ----------------------------------------------------------------------------
// tgql_back
// Expands each quad into six vertex beats and tracks the bounding box.
// ----------------------------------------------------------------------------
`default_nettype none

module tgql_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    input  wire tgql_pkg::quad_t        q_head,
    output logic                        q_pop,
    output logic                        vertex_valid,
    input  wire logic                   vertex_ready,
    output tgql_pkg::vertex_t           vertex
);

    logic [tgql_pkg::VTX_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    tgql_pkg::vertex_t              out_reg, out_next;
    tgql_pkg::pos_t                 min_x_reg, min_x_next;
    tgql_pkg::pos_t                 min_y_reg, min_y_next;
    tgql_pkg::pos_t                 max_x_reg, max_x_next;
    tgql_pkg::pos_t                 max_y_reg, max_y_next;

    tgql_pkg::pos_t                 px, py;
    tgql_pkg::pos_t                 b_min_x, b_min_y, b_max_x, b_max_y;
    logic                           load;
    logic                           fresh;
    logic                           use_left;
    logic                           use_top;

    assign load     = q_valid && (!out_valid_reg || vertex_ready);
    assign q_pop    = load && (cnt_reg == tgql_pkg::VTX_LAST);
    assign use_left = tgql_pkg::USE_LEFT[cnt_reg];
    assign use_top  = tgql_pkg::USE_TOP[cnt_reg];
    assign fresh    = q_head.clear_box && (cnt_reg == tgql_pkg::VTX_FIRST);

    assign px = use_left ? q_head.x_left : q_head.x_right;
    assign py = use_top  ? q_head.y_top  : q_head.y_bottom;

    assign b_min_x = fresh ? tgql_pkg::POS_HI : min_x_reg;
    assign b_min_y = fresh ? tgql_pkg::POS_HI : min_y_reg;
    assign b_max_x = fresh ? tgql_pkg::POS_LO : max_x_reg;
    assign b_max_y = fresh ? tgql_pkg::POS_LO : max_y_reg;

    always_comb
    begin
        min_x_next = (px < b_min_x) ? px : b_min_x;
        min_y_next = (py < b_min_y) ? py : b_min_y;
        max_x_next = (px > b_max_x) ? px : b_max_x;
        max_y_next = (py > b_max_y) ? py : b_max_y;

        out_next.vertex_x    = tgql_pkg::to_out(px);
        out_next.vertex_y    = tgql_pkg::to_out(py);
        out_next.vertex_u    = use_left ? q_head.u0 : q_head.u1;
        out_next.vertex_v    = use_top  ? q_head.v0 : q_head.v1;
        out_next.last_vertex = (cnt_reg == tgql_pkg::VTX_LAST);
        out_next.bound_min_x = tgql_pkg::to_out(min_x_next);
        out_next.bound_min_y = tgql_pkg::to_out(min_y_next);
        out_next.bound_max_x = tgql_pkg::to_out(max_x_next);
        out_next.bound_max_y = tgql_pkg::to_out(max_y_next);

        cnt_next = cnt_reg;
        if (load)
            cnt_next = (cnt_reg == tgql_pkg::VTX_LAST) ? tgql_pkg::VTX_FIRST : cnt_reg + 1'b1;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (vertex_ready)
            out_valid_next = 1'b0;
    end

    assign vertex_valid = out_valid_reg;
    assign vertex       = out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= tgql_pkg::VTX_FIRST;
            out_valid_reg <= 1'b0;
            min_x_reg     <= tgql_pkg::POS_HI;
            min_y_reg     <= tgql_pkg::POS_HI;
            max_x_reg     <= tgql_pkg::POS_LO;
            max_y_reg     <= tgql_pkg::POS_LO;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                max_x_reg <= max_x_next;
                max_y_reg <= max_y_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/text_glyph_quad_layout.sv @@
// ----------------------------------------------------------------------------
// text_glyph_quad_layout
// Lays out glyph quads from a character stream: pen tracking, whitespace
// handling, six vertices per drawable character with a running bounding box.
//
//   channel   dir   handshake                 beat
//   glyph     in    glyph_valid/glyph_ready   one character + atlas metrics
//   vertex    out   vertex_valid/vertex_ready one vertex + bounding box
//   cfg       in    cfg_we                    cfg_index, cfg_data
//
// Whitespace beats emit nothing; a drawable character emits six vertices,
// one at a time through the single vertex output register.
// The front keeps accepting beats while fewer than two quads wait in the queue.
// Reset: pen at origin, bounding box empty, newline metrics zero.
// A stalled vertex output backs up the queue, then glyph_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module text_glyph_quad_layout (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              glyph_valid,
    output logic                                   glyph_ready,
    input  wire tgql_pkg::glyph_t                  glyph,
    output logic                                   vertex_valid,
    input  wire logic                              vertex_ready,
    output tgql_pkg::vertex_t                      vertex,
    input  wire logic                              cfg_we,
    input  wire logic [tgql_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tgql_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tgql_pkg::q_status_t q_status;
    tgql_pkg::quad_t     q_data;
    tgql_pkg::quad_t     q_head;
    logic                q_push;
    logic                q_pop;

    tgql_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_valid (glyph_valid),
        .glyph_ready (glyph_ready),
        .glyph       (glyph),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_data      (q_data)
    );

    tgql_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .status    (q_status),
        .head      (q_head)
    );

    tgql_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_status.valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("quad pushed into full queue");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_status.valid)
        else $error("quad popped from empty queue");

    a_quad_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.valid && !q_pop) |=> q_status.valid)
        else $error("queued quad lost");

    a_box_covers: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> ($signed(vertex.bound_min_x) <= $signed(vertex.vertex_x)
                       && $signed(vertex.bound_max_x) >= $signed(vertex.vertex_x)
                       && $signed(vertex.bound_min_y) <= $signed(vertex.vertex_y)
                       && $signed(vertex.bound_max_y) >= $signed(vertex.vertex_y)))
        else $error("bounding box misses vertex");

endmodule

`default_nettype wire
